// ===== rtl/fra_pkg.sv =====
// Package for the fenced range allocator: command and status codes, defaults.
`default_nettype none
package fra_pkg;

   // Default sizes of the allocator.
   localparam int DEF_MAX_PAGES            = 8;
   localparam int DEF_FREE_RANGES_PER_PAGE = 16;
   localparam int DEF_STALLS_PER_PAGE      = 32;
   localparam int DEF_OFFSET_BITS          = 16;

   // Reset value of the page size register (32 * 1024 slots).
   localparam logic [15:0] PAGE_SLOTS_RESET = 16'd32768;

   // Command codes.
   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_FREE    = 3'd1;
   localparam logic [2:0] CMD_RENEW   = 3'd2;
   localparam logic [2:0] CMD_RELEASE = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   // Status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_OK_NEW     = 3'd1;
   localparam logic [2:0] ST_NO_PAGE    = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ST_BAD_PAGE   = 3'd4;
   localparam logic [2:0] ST_STALL_FULL = 3'd5;
   localparam logic [2:0] ST_FREE_FULL  = 3'd6;
   localparam logic [2:0] ST_IGNORED    = 3'd7;

endpackage
`default_nettype wire

// ===== rtl/fra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/fenced_range_allocator_unit.sv =====
// Fenced first-fit range allocator: sequencer over free-range and stall RAMs.
// Deallocate and clear-all are done in the idle state; allocate reads the free ranges one
// by one and steps over pages, and release reads each stalled range and walks or shifts
// free ranges when it is merged. One beat is in work at a time, as new beats are only taken
// in the idle state. Reset is synchronous: it closes all pages, clears the held counts,
// drops any pending result and sets page_slots to 32768.
`default_nettype none
module fenced_range_allocator_unit
   import fra_pkg::*;
#(
   parameter int MAX_PAGES            = DEF_MAX_PAGES,
   parameter int FREE_RANGES_PER_PAGE = DEF_FREE_RANGES_PER_PAGE,
   parameter int STALLS_PER_PAGE      = DEF_STALLS_PER_PAGE,
   parameter int OFFSET_BITS          = DEF_OFFSET_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [15:0] req_request_size,
   input  wire logic [2:0]  req_block_page,
   input  wire logic [14:0] req_block_offset,
   input  wire logic [15:0] req_block_size,
   input  wire logic [63:0] req_fence,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_granted_page,
   output logic [14:0]      rsp_granted_offset,
   output logic [8:0]       rsp_released_count
);

   localparam int OB          = OFFSET_BITS;
   localparam int PAGE_BITS   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PG_CNT_BITS = $clog2(MAX_PAGES + 1);
   localparam int FC_BITS     = $clog2(FREE_RANGES_PER_PAGE + 1);
   localparam int SC_BITS     = $clog2(STALLS_PER_PAGE + 1);
   localparam int FDEPTH      = MAX_PAGES * FREE_RANGES_PER_PAGE;
   localparam int SDEPTH      = MAX_PAGES * STALLS_PER_PAGE;
   localparam int FA_BITS     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int SA_BITS     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int FW          = 2 * OB;
   localparam int SW          = 2 * OB + 64;
   localparam logic [15:0] SLOT_LIMIT = 16'(1 << (OB - 1));

   typedef enum logic [14:0] {
      S_IDLE    = 15'b000000000000001,
      S_AL_RD   = 15'b000000000000010,
      S_AL_CHK  = 15'b000000000000100,
      S_AL_NEW  = 15'b000000000001000,
      S_DROP_RD = 15'b000000000010000,
      S_DROP_WR = 15'b000000000100000,
      S_RL_PAGE = 15'b000000001000000,
      S_RL_RD   = 15'b000000010000000,
      S_RL_CHK  = 15'b000000100000000,
      S_RL_KEEP = 15'b000001000000000,
      S_IN_RD   = 15'b000010000000000,
      S_IN_CHK  = 15'b000100000000000,
      S_IN_DEC  = 15'b001000000000000,
      S_UP_RD   = 15'b010000000000000,
      S_UP_WR   = 15'b100000000000000
   } state_type;

   // Address of a free-range entry and of a stall entry.
   function automatic logic [FA_BITS-1:0] free_addr(input logic [PAGE_BITS-1:0] p,
                                                    input logic [FC_BITS-1:0] i);
      return FA_BITS'(p) * FA_BITS'(FREE_RANGES_PER_PAGE) + FA_BITS'(i);
   endfunction

   function automatic logic [SA_BITS-1:0] stall_addr(input logic [PAGE_BITS-1:0] p,
                                                     input logic [SC_BITS-1:0] i);
      return SA_BITS'(p) * SA_BITS'(STALLS_PER_PAGE) + SA_BITS'(i);
   endfunction

   // Control state.
   state_type            state_ff, state_in;
   logic [15:0]          page_slots_ff, page_slots_in;
   logic                 in_use_ff [MAX_PAGES];
   logic                 in_use_in [MAX_PAGES];
   logic [FC_BITS-1:0]   free_held_ff [MAX_PAGES];
   logic [FC_BITS-1:0]   free_held_in [MAX_PAGES];
   logic [SC_BITS-1:0]   stall_held_ff [MAX_PAGES];
   logic [SC_BITS-1:0]   stall_held_in [MAX_PAGES];
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working registers of the current beat.
   logic                 rel_ff, rel_in;
   logic [PG_CNT_BITS-1:0] pg_ff, pg_in;
   logic [FC_BITS-1:0]   fi_ff, fi_in;
   logic [FC_BITS-1:0]   kx_ff, kx_in;
   logic [SC_BITS-1:0]   si_ff, si_in;
   logic [SC_BITS-1:0]   wi_ff, wi_in;
   logic [OB-1:0]        size_ff, size_in;
   logic [63:0]          fence_ff, fence_in;
   logic [SW-1:0]        ent_ff, ent_in;
   logic [FW-1:0]        prev_ff, prev_in;
   logic [FW-1:0]        cur_ff, cur_in;
   logic                 cur_vld_ff, cur_vld_in;
   logic [2:0]           st_ff, st_in;
   logic [8:0]           cnt_ff, cnt_in;
   logic [PAGE_BITS-1:0] gpg_ff, gpg_in;
   logic [OB-1:0]        goff_ff, goff_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_page_ff, rsp_page_in;
   logic [14:0]          rsp_offset_ff, rsp_offset_in;
   logic [8:0]           rsp_count_ff, rsp_count_in;

   // RAM ports.
   logic                 fw_en, fr_en, sw_en, sr_en;
   logic [FA_BITS-1:0]   fw_addr, fr_addr;
   logic [SA_BITS-1:0]   sw_addr, sr_addr;
   logic [FW-1:0]        fw_data, fr_data;
   logic [SW-1:0]        sw_data, sr_data;

   fra_ram #(.WIDTH(FW), .DEPTH(FDEPTH), .ADDR_BITS(FA_BITS)) u_free_ram (
      .clock   (clock),
      .wr_en   (fw_en),
      .wr_addr (fw_addr),
      .wr_data (fw_data),
      .rd_en   (fr_en),
      .rd_addr (fr_addr),
      .rd_data (fr_data)
   );

   fra_ram #(.WIDTH(SW), .DEPTH(SDEPTH), .ADDR_BITS(SA_BITS)) u_stall_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_en   (sr_en),
      .rd_addr (sr_addr),
      .rd_data (sr_data)
   );

   // Effective page size: zero counts as one, and it is saturated to 2**(OB-1) slots.
   logic [15:0]   slots16;
   logic [OB-1:0] slots_ob;
   assign slots16  = (page_slots_ff == 16'd0) ? 16'd1 :
                     ((page_slots_ff > SLOT_LIMIT) ? SLOT_LIMIT : page_slots_ff);
   assign slots_ob = slots16[OB-1:0];

   // Deallocate checks on the incoming beat.
   logic [PAGE_BITS-1:0] bp;
   logic [16:0]          blk_end;
   logic [2:0]           free_st;
   assign bp      = PAGE_BITS'(req_block_page);
   assign blk_end = {2'b00, req_block_offset} + {1'b0, req_block_size};

   always_comb begin
      if (!((32'(req_block_page) < MAX_PAGES) && in_use_ff[bp])) begin
         free_st = ST_BAD_PAGE;
      end else if (req_block_size == 16'd0 || req_block_size > slots16 ||
                   blk_end > {1'b0, slots16}) begin
         free_st = ST_IGNORED;
      end else if (stall_held_ff[bp] >= SC_BITS'(STALLS_PER_PAGE)) begin
         free_st = ST_STALL_FULL;
      end else begin
         free_st = ST_OK;
      end
   end

   // Lowest closed page, for opening a new one.
   logic                 np_found;
   logic [PAGE_BITS-1:0] np_idx;
   always_comb begin
      np_found = 1'b0;
      np_idx   = '0;
      for (int p = MAX_PAGES - 1; p >= 0; p--) begin
         if (!in_use_ff[p]) begin
            np_found = 1'b1;
            np_idx   = PAGE_BITS'(p);
         end
      end
   end

   // Field views of registered RAM data and working registers.
   logic [PAGE_BITS-1:0] pgi;
   logic [OB-1:0]        rd_start, rd_end, rd_diff, rd_next;
   logic [OB-1:0]        ent_s, ent_e;
   logic                 pm, nm;
   logic [FC_BITS-1:0]   n_free;
   logic [8:0]           cnt_inc;
   assign pgi      = pg_ff[PAGE_BITS-1:0];
   assign rd_start = fr_data[FW-1:OB];
   assign rd_end   = fr_data[OB-1:0];
   assign rd_diff  = rd_end - rd_start;
   assign rd_next  = rd_start + size_ff;
   assign ent_s    = ent_ff[SW-1:OB+64];
   assign ent_e    = ent_ff[OB+63:64];
   assign n_free   = free_held_ff[pgi];
   assign pm       = (fi_ff != '0) && (prev_ff[OB-1:0] == ent_s);
   assign nm       = cur_vld_ff && (cur_ff[FW-1:OB] == ent_e);
   assign cnt_inc  = (cnt_ff == 9'd511) ? cnt_ff : cnt_ff + 9'd1;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      page_slots_in = page_slots_ff;
      in_use_in     = in_use_ff;
      free_held_in  = free_held_ff;
      stall_held_in = stall_held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rel_in        = rel_ff;
      pg_in         = pg_ff;
      fi_in         = fi_ff;
      kx_in         = kx_ff;
      si_in         = si_ff;
      wi_in         = wi_ff;
      size_in       = size_ff;
      fence_in      = fence_ff;
      ent_in        = ent_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      cur_vld_in    = cur_vld_ff;
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      gpg_in        = gpg_ff;
      goff_in       = goff_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      fw_en   = 1'b0;
      fw_addr = '0;
      fw_data = '0;
      fr_en   = 1'b0;
      fr_addr = '0;
      sw_en   = 1'b0;
      sw_addr = '0;
      sw_data = '0;
      sr_en   = 1'b0;
      sr_addr = '0;
      req_ready = (state_ff == S_IDLE);

      if (csr_write_enable) begin
         page_slots_in = csr_write_data;
      end

      // A finished result moves to the output register once it is free.
      if (st_ff != 3'd0 || 1'b1) begin
         if (state_ff == S_IDLE && rel_ff && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = st_ff;
            rsp_page_in   = (st_ff > ST_OK_NEW) ? 3'd0 : 3'(gpg_ff);
            rsp_offset_in = (st_ff > ST_OK_NEW) ? 15'd0 : 15'(goff_ff);
            rsp_count_in  = cnt_ff;
            rel_in        = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            // rel_ff marks a pending result here; new beats wait until it can move to the output register.
            req_ready = !rel_ff || !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               rel_in     = 1'b0;
               pg_in      = '0;
               fi_in      = '0;
               cnt_in     = 9'd0;
               gpg_in     = '0;
               goff_in    = '0;
               st_in      = ST_OK;
               size_in    = OB'(req_request_size);
               fence_in   = req_fence;
               case (req_command)
                  CMD_ALLOC: begin
                     if (req_request_size == 16'd0) begin
                        st_in = ST_IGNORED;
                        rel_in = 1'b1;
                     end else if (req_request_size > slots16) begin
                        st_in = ST_TOO_LARGE;
                        rel_in = 1'b1;
                     end else begin
                        state_in = S_AL_RD;
                     end
                  end
                  CMD_FREE, CMD_RENEW: begin
                     if (req_command == CMD_RENEW && req_request_size == 16'd0) begin
                        st_in  = ST_IGNORED;
                        rel_in = 1'b1;
                     end else if ((req_command == CMD_FREE || req_block_size != 16'd0) &&
                                  free_st != ST_OK) begin
                        st_in  = free_st;
                        rel_in = 1'b1;
                     end else begin
                        if (req_command == CMD_FREE || req_block_size != 16'd0) begin
                           sw_en   = 1'b1;
                           sw_addr = stall_addr(bp, stall_held_ff[bp]);
                           sw_data = {OB'(req_block_offset), OB'(blk_end), req_fence};
                           stall_held_in[bp] = stall_held_ff[bp] + 1'b1;
                        end
                        if (req_command == CMD_FREE) begin
                           rel_in = 1'b1;
                        end else if (req_request_size > slots16) begin
                           st_in  = ST_TOO_LARGE;
                           rel_in = 1'b1;
                        end else begin
                           state_in = S_AL_RD;
                        end
                     end
                  end
                  CMD_RELEASE: begin
                     state_in = S_RL_PAGE;
                  end
                  CMD_CLEAR: begin
                     for (int p = 0; p < MAX_PAGES; p++) begin
                        in_use_in[p]     = 1'b0;
                        free_held_in[p]  = '0;
                        stall_held_in[p] = '0;
                     end
                     rel_in = 1'b1;
                  end
                  default: begin
                     st_in  = ST_IGNORED;
                     rel_in = 1'b1;
                  end
               endcase
            end
         end

         // First-fit walk over open pages and their free ranges.
         S_AL_RD: begin
            if (32'(pg_ff) >= MAX_PAGES) begin
               state_in = S_AL_NEW;
            end else if (!in_use_ff[pgi] || fi_ff == n_free) begin
               pg_in = pg_ff + 1'b1;
               fi_in = '0;
            end else begin
               fr_en    = 1'b1;
               fr_addr  = free_addr(pgi, fi_ff);
               state_in = S_AL_CHK;
            end
         end

         S_AL_CHK: begin
            if (rd_diff >= size_ff) begin
               gpg_in  = pgi;
               goff_in = rd_start;
               st_in   = ST_OK;
               if (rd_next == rd_end) begin
                  kx_in    = fi_ff;
                  state_in = S_DROP_RD;
               end else begin
                  fw_en    = 1'b1;
                  fw_addr  = free_addr(pgi, fi_ff);
                  fw_data  = {rd_next, rd_end};
                  rel_in   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               fi_in    = fi_ff + 1'b1;
               state_in = S_AL_RD;
            end
         end

         // Nothing fits: open the lowest closed page.
         S_AL_NEW: begin
            if (!np_found) begin
               st_in = ST_NO_PAGE;
            end else begin
               in_use_in[np_idx]     = 1'b1;
               stall_held_in[np_idx] = '0;
               free_held_in[np_idx]  = '0;
               if (size_ff < slots_ob) begin
                  fw_en   = 1'b1;
                  fw_addr = free_addr(np_idx, '0);
                  fw_data = {size_ff, slots_ob};
                  free_held_in[np_idx] = FC_BITS'(1);
               end
               gpg_in  = np_idx;
               goff_in = '0;
               st_in   = ST_OK_NEW;
            end
            rel_in   = 1'b1;
            state_in = S_IDLE;
         end

         // Close the gap at kx by moving the later ranges down one place.
         S_DROP_RD: begin
            if (FC_BITS'(kx_ff + 1'b1) < n_free) begin
               fr_en    = 1'b1;
               fr_addr  = free_addr(pgi, FC_BITS'(kx_ff + 1'b1));
               state_in = S_DROP_WR;
            end else begin
               free_held_in[pgi] = n_free - 1'b1;
               if (state_ff == S_DROP_RD && cur_vld_ff) begin
                  // Merge inside a release.
                  cnt_in     = cnt_inc;
                  si_in      = si_ff + 1'b1;
                  cur_vld_in = 1'b0;
                  state_in   = S_RL_RD;
               end else begin
                  rel_in   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         S_DROP_WR: begin
            fw_en    = 1'b1;
            fw_addr  = free_addr(pgi, kx_ff);
            fw_data  = fr_data;
            kx_in    = kx_ff + 1'b1;
            state_in = S_DROP_RD;
         end

         // Release: walk the open pages.
         S_RL_PAGE: begin
            if (32'(pg_ff) >= MAX_PAGES) begin
               rel_in   = 1'b1;
               state_in = S_IDLE;
            end else if (!in_use_ff[pgi]) begin
               pg_in = pg_ff + 1'b1;
            end else begin
               si_in    = '0;
               wi_in    = '0;
               state_in = S_RL_RD;
            end
         end

         S_RL_RD: begin
            cur_vld_in = 1'b0;
            if (si_ff == stall_held_ff[pgi]) begin
               stall_held_in[pgi] = wi_ff;
               pg_in    = pg_ff + 1'b1;
               state_in = S_RL_PAGE;
            end else begin
               sr_en    = 1'b1;
               sr_addr  = stall_addr(pgi, si_ff);
               state_in = S_RL_CHK;
            end
         end

         S_RL_CHK: begin
            ent_in = sr_data;
            if (sr_data[63:0] <= fence_ff) begin
               fi_in    = '0;
               state_in = S_IN_RD;
            end else begin
               state_in = S_RL_KEEP;
            end
         end

         // The stalled range stays: compact it to the write index.
         S_RL_KEEP: begin
            sw_en    = 1'b1;
            sw_addr  = stall_addr(pgi, wi_ff);
            sw_data  = ent_ff;
            wi_in    = wi_ff + 1'b1;
            si_in    = si_ff + 1'b1;
            state_in = S_RL_RD;
         end

         // Insert: find the first range that does not start below the new one.
         S_IN_RD: begin
            if (fi_ff < n_free) begin
               fr_en    = 1'b1;
               fr_addr  = free_addr(pgi, fi_ff);
               state_in = S_IN_CHK;
            end else begin
               state_in = S_IN_DEC;
            end
         end

         S_IN_CHK: begin
            if (rd_start < ent_s) begin
               prev_in  = fr_data;
               fi_in    = fi_ff + 1'b1;
               state_in = S_IN_RD;
            end else begin
               cur_in     = fr_data;
               cur_vld_in = 1'b1;
               state_in   = S_IN_DEC;
            end
         end

         S_IN_DEC: begin
            if (pm && nm) begin
               // Bridges both neighbors: widen the lower one, drop the upper.
               fw_en      = 1'b1;
               fw_addr    = free_addr(pgi, fi_ff - 1'b1);
               fw_data    = {prev_ff[FW-1:OB], cur_ff[OB-1:0]};
               kx_in      = fi_ff;
               cur_vld_in = 1'b1;
               state_in   = S_DROP_RD;
            end else if (pm) begin
               fw_en    = 1'b1;
               fw_addr  = free_addr(pgi, fi_ff - 1'b1);
               fw_data  = {prev_ff[FW-1:OB], ent_e};
               cnt_in   = cnt_inc;
               si_in    = si_ff + 1'b1;
               state_in = S_RL_RD;
            end else if (nm) begin
               fw_en    = 1'b1;
               fw_addr  = free_addr(pgi, fi_ff);
               fw_data  = {ent_s, cur_ff[OB-1:0]};
               cnt_in   = cnt_inc;
               si_in    = si_ff + 1'b1;
               state_in = S_RL_RD;
            end else if (n_free >= FC_BITS'(FREE_RANGES_PER_PAGE)) begin
               st_in    = ST_FREE_FULL;
               state_in = S_RL_KEEP;
            end else begin
               kx_in    = n_free;
               state_in = S_UP_RD;
            end
         end

         // Open a hole at fi by moving the later ranges up one place.
         S_UP_RD: begin
            if (kx_ff == fi_ff) begin
               fw_en    = 1'b1;
               fw_addr  = free_addr(pgi, fi_ff);
               fw_data  = {ent_s, ent_e};
               free_held_in[pgi] = n_free + 1'b1;
               cnt_in   = cnt_inc;
               si_in    = si_ff + 1'b1;
               state_in = S_RL_RD;
            end else begin
               fr_en    = 1'b1;
               fr_addr  = free_addr(pgi, kx_ff - 1'b1);
               state_in = S_UP_WR;
            end
         end

         S_UP_WR: begin
            fw_en    = 1'b1;
            fw_addr  = free_addr(pgi, kx_ff);
            fw_data  = fr_data;
            kx_in    = kx_ff - 1'b1;
            state_in = S_UP_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         page_slots_ff <= PAGE_SLOTS_RESET;
         rsp_valid_ff  <= 1'b0;
         rel_ff        <= 1'b0;
         cur_vld_ff    <= 1'b0;
         for (int p = 0; p < MAX_PAGES; p++) begin
            in_use_ff[p]     <= 1'b0;
            free_held_ff[p]  <= '0;
            stall_held_ff[p] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         page_slots_ff <= page_slots_in;
         rsp_valid_ff  <= rsp_valid_in;
         rel_ff        <= rel_in;
         cur_vld_ff    <= cur_vld_in;
         in_use_ff     <= in_use_in;
         free_held_ff  <= free_held_in;
         stall_held_ff <= stall_held_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      pg_ff         <= pg_in;
      fi_ff         <= fi_in;
      kx_ff         <= kx_in;
      si_ff         <= si_in;
      wi_ff         <= wi_in;
      size_ff       <= size_in;
      fence_ff      <= fence_in;
      ent_ff        <= ent_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      st_ff         <= st_in;
      cnt_ff        <= cnt_in;
      gpg_ff        <= gpg_in;
      goff_ff       <= goff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_page   = rsp_page_ff;
   assign rsp_granted_offset = rsp_offset_ff;
   assign rsp_released_count = rsp_count_ff;

endmodule
`default_nettype wire
